FILE: rtl/core/pba_pkg.sv
// Shared types, codes and constants of the page bitmap allocator.
package pba_pkg;

    localparam int PAGES_DEFAULT = 1024;
    localparam int WORD_BITS = 32;
    localparam int WORD_SHIFT = 5;
    localparam int FRAME_SHIFT = 12;
    localparam int ADDR_W = 32;
    localparam int COUNT_W = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'b1;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE = 1'b1
    } pba_op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK = 2'd0,
        STATUS_NO_FREE = 2'd1,
        STATUS_NOT_ALLOC = 2'd2,
        STATUS_RANGE = 2'd3
    } pba_status_t;

    typedef struct packed
    {
        pba_op_t op;
        logic [ADDR_W-1:0] page_address;
    } pba_req_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] result_address;
        pba_status_t status;
        logic [COUNT_W-1:0] free_pages;
    } pba_rsp_t;

    typedef enum logic [2:0]
    {
        SCAN_HOLD,
        SCAN_ZERO,
        SCAN_INC,
        SCAN_HINT,
        SCAN_FREE_WORD
    } pba_scan_sel_t;

    typedef struct packed
    {
        pba_scan_sel_t scan_sel;
        logic clear_wr;
        logic capture_req;
        logic alloc_take;
        logic alloc_skip;
        logic alloc_none;
        logic free_check;
        logic free_err;
        logic free_eval;
        logic rc_clear;
        logic rc_step;
        logic rc_commit;
        logic load_rsp;
    } pba_cmd_t;

    typedef struct packed
    {
        logic clear_last;
        logic recount_pending;
        logic word_beyond;
        logic word_has_free;
        logic free_range_err;
    } pba_stat_t;

endpackage

FILE: rtl/core/pba_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface pba_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/pba_ctrl.sv
// Sequencer of the page bitmap allocator: clear, recount, allocate and free flows.
module pba_ctrl
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input pba_pkg::pba_op_t req_op,
    input logic rsp_ready,
    input pba_pkg::pba_stat_t stat,
    output logic req_ready,
    output logic rsp_valid,
    output pba_pkg::pba_cmd_t cmd
);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_RECOUNT,
        ST_ALLOC,
        ST_FREE_CHECK,
        ST_FREE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && !stat.recount_pending;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.scan_sel = pba_pkg::SCAN_HOLD;
        state_next = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.scan_sel = pba_pkg::SCAN_INC;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                priority if (stat.recount_pending)
                begin
                    cmd.scan_sel = pba_pkg::SCAN_ZERO;
                    cmd.rc_clear = 1'b1;
                    state_next = ST_RECOUNT;
                end
                else if (req_valid)
                begin
                    cmd.capture_req = 1'b1;
                    if (req_op == pba_pkg::OP_ALLOC)
                    begin
                        cmd.scan_sel = pba_pkg::SCAN_HINT;
                        state_next = ST_ALLOC;
                    end
                    else
                    begin
                        state_next = ST_FREE_CHECK;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RECOUNT:
            begin
                if (stat.word_beyond)
                begin
                    cmd.rc_commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rc_step = 1'b1;
                    cmd.scan_sel = pba_pkg::SCAN_INC;
                end
            end
            ST_ALLOC:
            begin
                priority if (stat.word_beyond)
                begin
                    cmd.alloc_none = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.word_has_free)
                begin
                    cmd.alloc_take = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.alloc_skip = 1'b1;
                    cmd.scan_sel = pba_pkg::SCAN_INC;
                end
            end
            ST_FREE_CHECK:
            begin
                cmd.free_check = 1'b1;
                if (stat.free_range_err)
                begin
                    cmd.free_err = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_sel = pba_pkg::SCAN_FREE_WORD;
                    state_next = ST_FREE;
                end
            end
            ST_FREE:
            begin
                cmd.free_eval = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_rsp = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: rtl/core/pba_dp.sv
// Datapath of the page bitmap allocator: bitmap memory, counters, search and result registers.
module pba_dp #(
    parameter int PAGES = pba_pkg::PAGES_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic cfg_we,
    input logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [pba_pkg::CFG_DATA_W-1:0] cfg_data,
    input pba_pkg::pba_req_t req_data,
    input pba_pkg::pba_cmd_t cmd,
    output pba_pkg::pba_stat_t stat,
    output pba_pkg::pba_rsp_t rsp_data
);

    localparam int WB = pba_pkg::WORD_BITS;
    localparam int BS = pba_pkg::WORD_SHIFT;
    localparam int AW = pba_pkg::ADDR_W;
    localparam int WORDS = (PAGES + WB - 1) / WB;
    localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW = $clog2(WORDS + 1);
    localparam int PW = SW + BS;

    logic [AW-1:0] base_reg;
    logic [pba_pkg::COUNT_W-1:0] count_reg;
    logic recount_pending_reg;

    logic [WB-1:0] mem [WORDS];
    logic [WB-1:0] rdata_reg;
    logic wr_en;
    logic [WB-1:0] wr_data;

    logic [SW-1:0] scan_reg;
    logic [SW-1:0] scan_next;
    logic [SW-1:0] hint_reg;
    logic [PW-1:0] used_low_reg;
    logic [PW-1:0] rc_acc_reg;
    logic [AW-1:0] req_addr_reg;
    logic [PW-1:0] fidx_reg;
    logic [AW-1:0] res_addr_reg;
    pba_pkg::pba_status_t res_status_reg;
    pba_pkg::pba_rsp_t out_reg;

    logic [PW-1:0] n_w;
    logic [AW-1:0] base_al;
    logic [AW-1:0] idx32;
    logic range_err;
    logic [PW-1:0] start_w;
    logic [PW-1:0] rem_w;
    logic beyond;
    logic [WB-1:0] vmask;
    logic [WB-1:0] avail;
    logic [BS-1:0] fbit;
    logic [PW-1:0] take_idx;
    logic [AW-1:0] take_addr;
    logic word_full;
    logic free_bit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            count_reg <= pba_pkg::PAGE_COUNT_RESET;
            recount_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == pba_pkg::REG_BASE_ADDRESS))
            begin
                base_reg <= cfg_data[AW-1:0];
            end
            if (cfg_we && (cfg_index == pba_pkg::REG_PAGE_COUNT))
            begin
                count_reg <= cfg_data[pba_pkg::COUNT_W-1:0];
                recount_pending_reg <= 1'b1;
            end
            else if (cmd.rc_commit)
            begin
                recount_pending_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (32'(count_reg) > 32'(PAGES))
        begin
            n_w = PW'(PAGES);
        end
        else
        begin
            n_w = PW'(count_reg);
        end
    end

    assign base_al = {base_reg[AW-1:pba_pkg::FRAME_SHIFT], {pba_pkg::FRAME_SHIFT{1'b0}}};

    // Free address check
    assign idx32 = (req_addr_reg - base_al) >> pba_pkg::FRAME_SHIFT;
    assign range_err = (req_addr_reg < base_al) || (idx32 >= 32'(n_w));

    // Word under the scan pointer
    assign start_w = {scan_reg, {BS{1'b0}}};
    assign beyond = start_w >= n_w;
    assign rem_w = n_w - start_w;
    assign vmask = (rem_w >= PW'(WB)) ? '1 : ((WB'(1) << rem_w[BS-1:0]) - WB'(1));
    assign avail = ~rdata_reg & vmask;
    assign word_full = &rdata_reg;
    assign free_bit = rdata_reg[fidx_reg[BS-1:0]];

    always_comb
    begin
        fbit = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                fbit = BS'(i);
            end
        end
    end

    assign take_idx = {scan_reg, fbit};
    assign take_addr = base_al + (32'(take_idx) << pba_pkg::FRAME_SHIFT);

    always_comb
    begin
        unique case (cmd.scan_sel)
            pba_pkg::SCAN_HOLD: scan_next = scan_reg;
            pba_pkg::SCAN_ZERO: scan_next = '0;
            pba_pkg::SCAN_INC: scan_next = scan_reg + 1'b1;
            pba_pkg::SCAN_HINT: scan_next = hint_reg;
            pba_pkg::SCAN_FREE_WORD: scan_next = idx32[PW-1:BS];
            default: scan_next = scan_reg;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_data = rdata_reg;
        priority if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
            wr_data = '0;
        end
        else if (cmd.alloc_take)
        begin
            wr_en = 1'b1;
            wr_data = rdata_reg | (WB'(1) << fbit);
        end
        else if (cmd.free_eval && free_bit)
        begin
            wr_en = 1'b1;
            wr_data = rdata_reg & ~(WB'(1) << fidx_reg[BS-1:0]);
        end
        else
        begin
            wr_en = 1'b0;
            wr_data = rdata_reg;
        end
    end

    // Bitmap memory: one write at the scan word, registered read of the next scan word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[scan_reg[WA-1:0]] <= wr_data;
        end
        rdata_reg <= mem[scan_next[WA-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            hint_reg <= '0;
            used_low_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            priority if (cmd.alloc_take)
            begin
                hint_reg <= scan_reg;
                used_low_reg <= used_low_reg + 1'b1;
            end
            else if (cmd.alloc_skip)
            begin
                if (word_full && (scan_reg == hint_reg))
                begin
                    hint_reg <= hint_reg + 1'b1;
                end
            end
            else if (cmd.free_eval && free_bit)
            begin
                if (scan_reg < hint_reg)
                begin
                    hint_reg <= scan_reg;
                end
                used_low_reg <= used_low_reg - 1'b1;
            end
            else if (cmd.rc_commit)
            begin
                used_low_reg <= rc_acc_reg;
            end
            else
            begin
                used_low_reg <= used_low_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_req)
        begin
            req_addr_reg <= req_data.page_address;
        end
        if (cmd.free_check)
        begin
            fidx_reg <= idx32[PW-1:0];
        end
        if (cmd.rc_clear)
        begin
            rc_acc_reg <= '0;
        end
        else if (cmd.rc_step)
        begin
            rc_acc_reg <= rc_acc_reg + PW'($countones(rdata_reg & vmask));
        end
        priority if (cmd.alloc_take)
        begin
            res_addr_reg <= take_addr;
            res_status_reg <= pba_pkg::STATUS_OK;
        end
        else if (cmd.alloc_none)
        begin
            res_addr_reg <= '0;
            res_status_reg <= pba_pkg::STATUS_NO_FREE;
        end
        else if (cmd.free_err)
        begin
            res_addr_reg <= '0;
            res_status_reg <= pba_pkg::STATUS_RANGE;
        end
        else if (cmd.free_eval)
        begin
            res_addr_reg <= '0;
            res_status_reg <= free_bit ? pba_pkg::STATUS_OK : pba_pkg::STATUS_NOT_ALLOC;
        end
        else
        begin
            res_addr_reg <= res_addr_reg;
            res_status_reg <= res_status_reg;
        end
        if (cmd.load_rsp)
        begin
            out_reg.result_address <= res_addr_reg;
            out_reg.status <= res_status_reg;
            out_reg.free_pages <= pba_pkg::COUNT_W'(n_w - used_low_reg);
        end
    end

    assign stat.clear_last = (scan_reg == SW'(WORDS - 1));
    assign stat.recount_pending = recount_pending_reg;
    assign stat.word_beyond = beyond;
    assign stat.word_has_free = |avail;
    assign stat.free_range_err = range_err;
    assign rsp_data = out_reg;

endmodule

FILE: rtl/core/page_bitmap_allocator_unit.sv
// Top level of the first-fit page bitmap allocator.
//
// req carries one item per handshake: op (allocate or free) and page_address.
// rsp returns one item per request: result_address, status and free_pages.
// The config port writes base_address (index 0) and page_count (index 1);
// write it only while no request is in flight.
//
// Flow: an allocate scans the 32-page bitmap words one word a cycle, from the
// lowest word that may hold a free page, until it finds a free page or passes
// the managed range; a free checks the address range, then reads the frame's
// word and clears its bit if set. A new request is accepted only once the
// previous response has been loaded into the output register.
// After reset a clearing pass writes zeros over the bitmap, one word a cycle;
// req.ready stays low meanwhile.
// A write to page_count starts a recount of the used pages among the first n,
// n being page_count saturated at PAGES, one word a cycle; req.ready stays
// low after the write until the recount ends.
// The response sits in an output register; while the receiver stalls it
// holds, and a new item may be accepted and processed, then waits behind it.
module page_bitmap_allocator_unit #(
    parameter int PAGES = pba_pkg::PAGES_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    pba_stream_if.sink req,
    pba_stream_if.source rsp,
    input logic cfg_we,
    input logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [pba_pkg::CFG_DATA_W-1:0] cfg_data
);

    pba_pkg::pba_cmd_t cmd;
    pba_pkg::pba_stat_t stat;
    pba_pkg::pba_req_t req_item;
    pba_pkg::pba_rsp_t rsp_item;
    logic req_ready;
    logic rsp_valid;

    assign req_item = req.data;

    // Sequence the flows
    pba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req_item.op),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .cmd       (cmd)
    );

    // Hold the bitmap, counters and result
    pba_dp #(
        .PAGES (PAGES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_data  (rsp_item)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data = rsp_item;

    // One item in flight: drop ready right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready) |=> !req_ready)
        else $error("item accepted while another is in flight");

    // No free page means the reported free count is zero
    a_no_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.status == pba_pkg::STATUS_NO_FREE))
            |-> (rsp_item.free_pages == '0))
        else $error("no free page reported with nonzero free count");

    // Errors carry a zero address
    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.status != pba_pkg::STATUS_OK))
            |-> (rsp_item.result_address == '0))
        else $error("error result with nonzero address");

endmodule

FILE: tb/page_bitmap_allocator_unit_tb.sv
// Self-checking testbench for the first-fit page bitmap allocator.
module page_bitmap_allocator_unit_tb;

    import pba_pkg::*;

    localparam int PAGES = PAGES_DEFAULT;
    localparam int RANDOM_PHASES = 9;
    localparam int PRESSURE_PHASE = 7;
    localparam int EMPTY_PHASE = 6;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;

    typedef struct
    {
        bit is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0] value;
        pba_op_t op;
        bit typed;
        pba_rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pba_stream_if #(.T(pba_rsp_t)) rsp_if ();
    pba_stream_if #(.T(pba_req_t)) req_if ();

    page_bitmap_allocator_unit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow of the allocator: one used flag per frame plus both registers.
    bit frame_used [PAGES];
    logic [ADDR_W-1:0] base_reg = '0;
    logic [COUNT_W-1:0] count_reg = PAGE_COUNT_RESET;

    // Responses still owed by the block, oldest first.
    pba_rsp_t awaited_rsp_q [$];
    plan_row_t plan_q [$];

    int mismatch_count = 0;
    bit quiet = 1'b0;
    bit sender_pacing = 1'b1;
    bit long_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or stops answering.
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Frames actually managed: page_count saturates at the bitmap size.
    function automatic int managed_frames();
        return (count_reg > PAGES) ? PAGES : int'(count_reg);
    endfunction

    // Apply one request to the shadow bitmap and return the response it owes.
    function automatic pba_rsp_t predict_page_op(pba_op_t op, logic [ADDR_W-1:0] addr);
        pba_rsp_t r;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] frame;
        int n;
        int found;
        int free_cnt;
        base = base_reg & ~32'h0000_0FFF;
        n = managed_frames();
        r.result_address = '0;
        r.status = STATUS_OK;
        found = -1;
        if (op == OP_ALLOC)
        begin
            // First fit: lowest clear flag among the managed frames.
            for (int i = 0; i < n && found < 0; i++)
                if (!frame_used[i])
                    found = i;
            if (found >= 0)
            begin
                frame_used[found] = 1'b1;
                frame = found;
                r.result_address = base + (frame << FRAME_SHIFT);
            end
            else
                r.status = STATUS_NO_FREE;
        end
        else if (addr < base)
            r.status = STATUS_RANGE;
        else
        begin
            // Drop the in-page offset; the subtraction cannot wrap here.
            frame = (addr - base) >> FRAME_SHIFT;
            if (frame >= n)
                r.status = STATUS_RANGE;
            else if (frame_used[frame])
                frame_used[frame] = 1'b0;
            else
                r.status = STATUS_NOT_ALLOC;
        end
        // Frames beyond a lowered count keep their flags but are not counted.
        free_cnt = 0;
        for (int i = 0; i < n; i++)
            if (!frame_used[i])
                free_cnt++;
        r.free_pages = COUNT_W'(free_cnt);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan rows
    // ------------------------------------------------------------------

    function automatic void plan_write(logic [CFG_IDX_W-1:0] index,
                                       logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row = '{is_write: 1'b1, reg_index: index, value: value, op: OP_ALLOC,
                typed: 1'b0, want: '0};
        plan_q.push_back(row);
    endfunction

    function automatic void plan_op(pba_op_t op, logic [ADDR_W-1:0] addr);
        plan_row_t row;
        row = '{is_write: 1'b0, reg_index: REG_BASE_ADDRESS, value: addr, op: op,
                typed: 1'b0, want: '0};
        plan_q.push_back(row);
    endfunction

    // A row whose response is written out in full rather than predicted.
    function automatic void plan_check(pba_op_t op, logic [ADDR_W-1:0] addr,
                                       logic [ADDR_W-1:0] result_address,
                                       pba_status_t status,
                                       logic [COUNT_W-1:0] free_pages);
        plan_row_t row;
        row = '{is_write: 1'b0, reg_index: REG_BASE_ADDRESS, value: addr, op: op,
                typed: 1'b1,
                want: '{result_address: result_address, status: status,
                        free_pages: free_pages}};
        plan_q.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item, hold it until the block takes it, then log what it owes.
    task automatic offer_request(pba_op_t op, logic [ADDR_W-1:0] addr, bit typed,
                                 pba_rsp_t want);
        pba_req_t item;
        pba_rsp_t predicted;
        item.op = op;
        item.page_address = addr;
        req_if.valid <= 1'b1;
        req_if.data <= item;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predicted = predict_page_op(op, addr);
        awaited_rsp_q.push_back(typed ? want : predicted);
        // Drop valid for a random burst now and then; otherwise keep it high
        // so the next item follows back to back.
        if (!quiet && sender_pacing && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Registers change only with nothing in flight: hold requests, let every
    // owed response come back, then write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        req_if.valid <= 1'b0;
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_BASE_ADDRESS)
            base_reg = value;
        else
            count_reg = value[COUNT_W-1:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: ready pacing in its own process
    // ------------------------------------------------------------------

    initial
    begin : rsp_pacer
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                // Long hold: the output register fills, then the input stalls.
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string field, logic [31:0] want,
                                          logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, field, want, got);
    endfunction

    always @(posedge clk)
    begin : rsp_checker
        pba_rsp_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (awaited_rsp_q.size() == 0)
                note_mismatch("unrequested item", '0, rsp_if.data.result_address);
            else
            begin
                want = awaited_rsp_q.pop_front();
                if (rsp_if.data.result_address !== want.result_address)
                    note_mismatch("result_address", want.result_address,
                                  rsp_if.data.result_address);
                if (rsp_if.data.status !== want.status)
                    note_mismatch("status", want.status, rsp_if.data.status);
                if (rsp_if.data.free_pages !== want.free_pages)
                    note_mismatch("free_pages", want.free_pages, rsp_if.data.free_pages);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int items_in_phase;
        int alloc_pct;
        int pick;
        int n;
        logic [ADDR_W-1:0] new_base;
        logic [ADDR_W-1:0] base_al;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] frame_sel;
        logic [CFG_DATA_W-1:0] count_word;
        int new_count;
        pba_op_t op;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_BASE_ADDRESS;
        cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // The clearing pass after reset keeps req.ready low; the handshake
        // wait in offer_request covers it.
        @(posedge clk);

        // Directed part, from the reset settings: base 0, 1024 frames.
        plan_check(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, STATUS_OK, 11'd1023);
        plan_check(OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_1000, STATUS_OK, 11'd1022);
        // Offset bits are dropped: this frees frame 0.
        plan_check(OP_FREE, 32'h0000_0FFF, 32'h0000_0000, STATUS_OK, 11'd1023);
        plan_check(OP_FREE, 32'h0000_0000, 32'h0000_0000, STATUS_NOT_ALLOC, 11'd1023);
        plan_op(OP_ALLOC, 32'h1234_5678);
        plan_check(OP_FREE, 32'hFFFF_FFFF, 32'h0000_0000, STATUS_RANGE, 11'd1022);
        // First index past the managed range, then the last managed frame.
        plan_check(OP_FREE, 32'h0040_0000, 32'h0000_0000, STATUS_RANGE, 11'd1022);
        plan_check(OP_FREE, 32'h003F_F123, 32'h0000_0000, STATUS_NOT_ALLOC, 11'd1022);
        plan_op(OP_FREE, 32'h0000_1000);
        // Unaligned base and no frames managed at all.
        plan_write(REG_BASE_ADDRESS, 32'h8000_0ABC);
        plan_write(REG_PAGE_COUNT, 32'h0000_0000);
        plan_check(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, STATUS_NO_FREE, 11'd0);
        plan_check(OP_FREE, 32'h8000_0000, 32'h0000_0000, STATUS_RANGE, 11'd0);
        // Count above the bitmap size saturates; junk above bit 10 is ignored.
        plan_write(REG_PAGE_COUNT, 32'hFFFF_F7FF);
        plan_op(OP_ALLOC, 32'h0000_0000);
        plan_check(OP_FREE, 32'h7FFF_FFFF, 32'h0000_0000, STATUS_RANGE, 11'd1022);
        plan_op(OP_FREE, 32'h8000_0000);
        // Top-of-memory base: result addresses wrap around.
        plan_write(REG_BASE_ADDRESS, 32'hFFFF_F000);
        plan_write(REG_PAGE_COUNT, 32'd3);
        plan_op(OP_ALLOC, 32'hFFFF_FFFF);
        plan_op(OP_ALLOC, 32'h0000_0000);
        plan_check(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, STATUS_NO_FREE, 11'd0);
        plan_op(OP_FREE, 32'hFFFF_FFFF);
        // Lowered count: frames 1 and 2 stay used but drop out of view.
        plan_write(REG_PAGE_COUNT, 32'd1);
        plan_check(OP_FREE, 32'h0000_0000, 32'h0000_0000, STATUS_RANGE, 11'd1);
        plan_op(OP_ALLOC, 32'h0000_0000);
        plan_check(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, STATUS_NO_FREE, 11'd0);
        plan_write(REG_BASE_ADDRESS, 32'h0000_0000);
        plan_write(REG_PAGE_COUNT, 32'd1024);
        plan_op(OP_ALLOC, 32'h0000_0000);
        plan_op(OP_FREE, 32'h0000_2000);

        foreach (plan_q[r])
        begin
            if (plan_q[r].is_write)
                write_reg(plan_q[r].reg_index, plan_q[r].value);
            else
                offer_request(plan_q[r].op, plan_q[r].value, plan_q[r].typed,
                              plan_q[r].want);
        end

        // Random part: one register setting per phase, extremes included.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            new_base = $urandom();
            case (phase)
                0:
                begin
                    new_base = '0;
                    new_count = PAGES;
                end
                1: new_count = $urandom_range(1, 40);
                2:
                begin
                    new_base = 32'hFFFF_F000;
                    new_count = 1;
                end
                3:
                begin
                    // Straddle bitmap words so the scan walks several of them.
                    new_base = new_base & ~32'h0000_0FFF;
                    new_count = $urandom_range(33, 96);
                end
                4: new_count = $urandom_range(PAGES + 1, 2047);
                EMPTY_PHASE: new_count = 0;
                PRESSURE_PHASE: new_count = $urandom_range(1, 64);
                default: new_count = $urandom_range(1, PAGES);
            endcase
            count_word = new_count;
            if ($urandom_range(0, 1) == 1)
                count_word[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W - COUNT_W)'($urandom());

            // Every phase change is also a full sender pause: write_reg drains.
            write_reg(REG_BASE_ADDRESS, new_base);
            write_reg(REG_PAGE_COUNT, count_word);

            quiet = (phase == RANDOM_PHASES - 1);
            sender_pacing = (phase != PRESSURE_PHASE);
            if (phase == PRESSURE_PHASE)
                long_hold_req = 1'b1;
            items_in_phase = (phase == EMPTY_PHASE) ? 12 : 52;
            alloc_pct = $urandom_range(35, 70);

            for (int k = 0; k < items_in_phase; k++)
            begin
                op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
                n = managed_frames();
                base_al = base_reg & ~32'h0000_0FFF;
                pick = $urandom_range(1, 100);
                if (op == OP_ALLOC)
                    addr = $urandom();
                else if (pick <= 60 && n > 0)
                begin
                    // Mostly low frames, where first fit has put the used ones.
                    frame_sel = $urandom_range(0, (n > 64) ? 63 : n - 1);
                    addr = base_al + (frame_sel << FRAME_SHIFT) + $urandom_range(0, 4095);
                end
                else if (pick <= 75)
                begin
                    frame_sel = n + $urandom_range(0, 5);
                    addr = base_al + (frame_sel << FRAME_SHIFT) + $urandom_range(0, 4095);
                end
                else if (pick <= 85 && base_al != 0)
                    addr = $urandom_range(0, base_al - 1);
                else
                    addr = $urandom();
                offer_request(op, addr, 1'b0, '0);
            end
        end

        // Wind down: nothing more offered, wait for every owed item, then
        // give stray late items a chance to show up.
        req_if.valid <= 1'b0;
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
